[rtl/assert_macros.svh]
// assertion helpers, included by sorted_key_set_insert
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define SKS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define SKS_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[rtl/sks_pkg.sv]
// ----------------------------------------------------------------------------
// sks_pkg
// Shared constants and types of the sorted key set: store size, field widths,
// result status codes and the key store port structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sks_pkg;

	localparam int CAPACITY = 32;
	localparam int KEY_W    = 31;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int OCC_W    = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_FULL      = 2'd2,
		ST_DUMP      = 2'd3
	} status_t;

	// access of the sequencer to the key store
	typedef struct packed {
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [KEY_W-1:0] wr_data;
	} store_req_t;

	// shared comparator: registered stored key against the probe key
	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

endpackage

`default_nettype wire

[rtl/sks_if.sv]
// ----------------------------------------------------------------------------
// sks_in_if / sks_out_if
// Valid/ready channels of the sorted key set: command words in, result
// words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sks_in_if;
	import sks_pkg::*;

	logic             valid;
	logic             ready;
	logic             cmd;
	logic [KEY_W-1:0] key;

	modport source (output valid, output cmd, output key, input ready);
	modport sink (input valid, input cmd, input key, output ready);
endinterface

interface sks_out_if;
	import sks_pkg::*;

	logic             valid;
	logic             ready;
	status_t          status;
	logic [KEY_W-1:0] key_out;
	logic             entry_valid;
	logic             last;

	modport source (output valid, output status, output key_out, output entry_valid,
		output last, input ready);
	modport sink (input valid, input status, input key_out, input entry_valid,
		input last, output ready);
endinterface

`default_nettype wire

[rtl/sks_key_store.sv]
// ----------------------------------------------------------------------------
// sks_key_store
// Key memory with one write and one registered read port, plus the shared
// magnitude comparator that tests the read key against the probe key.
// ----------------------------------------------------------------------------
`default_nettype none

module sks_key_store (
	input  wire logic                     clk,
	input  wire sks_pkg::store_req_t      req,
	input  wire logic [sks_pkg::KEY_W-1:0] probe,
	output logic      [sks_pkg::KEY_W-1:0] rd_data,
	output sks_pkg::cmp_res_t             cmp
);
	import sks_pkg::*;

	logic [KEY_W-1:0] mem_q [CAPACITY];
	logic [KEY_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem_q[req.rd_addr];
	end

	assign rd_data = rd_q;
	assign cmp.lt  = rd_q < probe;
	assign cmp.eq  = rd_q == probe;

endmodule

`default_nettype wire

[rtl/sorted_key_set_insert.sv]
// ----------------------------------------------------------------------------
// sorted_key_set_insert
// Bounded set of keys kept in ascending order. Insert places a key at its
// sorted slot, rejecting duplicates and inserts into a full store; dump
// streams all stored keys in ascending order.
// ----------------------------------------------------------------------------
//
//   channel  dir  word                                   handshake
//   req      in   cmd, key                               valid / ready
//   rsp      out  status, key_out, entry_valid, last     valid / ready
//
// insert: scans slots one at a time (read, then compare) up to the first key
//   not below the new key, then moves each larger key up (read, then write)
//   and writes the new key; the single read port and one comparator serialize it
// dump: one read and one result word per stored key; a single result word when empty
// req.ready is high only while the sequencer is idle; a result word waiting
//   in the output register does not hold off the next command
// reset empties the set at once; no clearing pass over the key memory
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sorted_key_set_insert (
	input wire logic clk,
	input wire logic arst_n,
	sks_in_if.sink   req,
	sks_out_if.source rsp
);
	import sks_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_WR_KEY,
		S_DUMP_RD,
		S_DUMP_OUT,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [OCC_W-1:0] occ_q;
	logic [OCC_W-1:0] ptr_q;
	logic [OCC_W-1:0] pos_q;
	logic [KEY_W-1:0] key_q;
	status_t          status_q;

	logic             out_valid_q;
	status_t          out_status_q;
	logic [KEY_W-1:0] out_key_q;
	logic             out_entry_valid_q;
	logic             out_last_q;

	logic [OCC_W-1:0] ptr_inc;
	logic [OCC_W-1:0] ptr_dec;
	logic [OCC_W-1:0] pos_d;
	logic [OCC_W-1:0] rd_ptr;
	logic             slot_free;
	logic             store_full;
	logic             out_load;

	store_req_t       store_req;
	logic [KEY_W-1:0] rd_data;
	cmp_res_t         cmp;

	assign ptr_inc    = OCC_W'(ptr_q + 1'b1);
	assign ptr_dec    = OCC_W'(ptr_q - 1'b1);
	assign pos_d      = cmp.lt ? ptr_inc : ptr_q;
	assign slot_free  = !out_valid_q || rsp.ready;
	assign store_full = occ_q == OCC_W'(CAPACITY);

	// a new result word goes into the output register this cycle
	assign out_load = slot_free && ((state_q == S_DUMP_OUT) || (state_q == S_DONE));

	// moving a key up reads the slot below the one being written
	assign rd_ptr = (state_q == S_SHIFT_RD) ? ptr_dec : ptr_q;

	always_comb begin
		store_req.rd_addr = rd_ptr[IDX_W-1:0];
		store_req.wr_en   = (state_q == S_SHIFT_WR) || (state_q == S_WR_KEY);
		if (state_q == S_SHIFT_WR) begin
			store_req.wr_addr = ptr_q[IDX_W-1:0];
			store_req.wr_data = rd_data;
		end else begin
			store_req.wr_addr = pos_q[IDX_W-1:0];
			store_req.wr_data = key_q;
		end
	end

	sks_key_store u_store (
		.clk     (clk),
		.req     (store_req),
		.probe   (key_q),
		.rd_data (rd_data),
		.cmp     (cmp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			occ_q             <= '0;
			ptr_q             <= '0;
			pos_q             <= '0;
			key_q             <= '0;
			status_q          <= ST_INSERTED;
			out_valid_q       <= 1'b0;
			out_status_q      <= ST_INSERTED;
			out_key_q         <= '0;
			out_entry_valid_q <= 1'b0;
			out_last_q        <= 1'b0;
		end else begin
			if (rsp.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						key_q <= req.key;
						ptr_q <= '0;
						pos_q <= '0;
						if (req.cmd) begin
							if (occ_q == '0) begin
								status_q <= ST_DUMP;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_DUMP_RD;
							end
						end else if (occ_q == '0) begin
							state_q <= S_WR_KEY;
						end else begin
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					if (cmp.eq) begin
						status_q <= ST_DUPLICATE;
						state_q  <= S_DONE;
					end else if (cmp.lt && (ptr_inc != occ_q)) begin
						ptr_q   <= ptr_inc;
						state_q <= S_SCAN_RD;
					end else if (store_full) begin
						status_q <= ST_FULL;
						state_q  <= S_DONE;
					end else begin
						// slot found: move keys up from the top down to it
						pos_q <= pos_d;
						ptr_q <= occ_q;
						state_q <= (occ_q == pos_d) ? S_WR_KEY : S_SHIFT_RD;
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					ptr_q   <= ptr_dec;
					state_q <= (ptr_dec == pos_q) ? S_WR_KEY : S_SHIFT_RD;
				end
				S_WR_KEY: begin
					occ_q    <= OCC_W'(occ_q + 1'b1);
					status_q <= ST_INSERTED;
					state_q  <= S_DONE;
				end
				S_DUMP_RD: begin
					state_q <= S_DUMP_OUT;
				end
				S_DUMP_OUT: begin
					if (slot_free) begin
						out_valid_q       <= 1'b1;
						out_status_q      <= ST_DUMP;
						out_key_q         <= rd_data;
						out_entry_valid_q <= 1'b1;
						out_last_q        <= ptr_inc == occ_q;
						if (ptr_inc == occ_q) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q   <= ptr_inc;
							state_q <= S_DUMP_RD;
						end
					end
				end
				S_DONE: begin
					if (slot_free) begin
						out_valid_q       <= 1'b1;
						out_status_q      <= status_q;
						out_key_q         <= '0;
						out_entry_valid_q <= 1'b0;
						out_last_q        <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready       = state_q == S_IDLE;
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.key_out     = out_key_q;
	assign rsp.entry_valid = out_entry_valid_q;
	assign rsp.last        = out_last_q;

	`SKS_NEVER(a_occ_bound, clk, arst_n, occ_q > OCC_W'(CAPACITY), "occupancy above capacity")
	`SKS_ASSERT(a_no_write_full, clk, arst_n, store_req.wr_en |-> !store_full,
		"key store written while full")
	`SKS_ASSERT(a_occ_step, clk, arst_n, !$stable(occ_q) |-> occ_q == OCC_W'($past(occ_q) + 1'b1),
		"occupancy moved by other than one")
	`SKS_ASSERT(a_shift_above_pos, clk, arst_n,
		(state_q == S_SHIFT_RD || state_q == S_SHIFT_WR) |-> ptr_q > pos_q,
		"key move below insert slot")

endmodule

`default_nettype wire
